// File: rtl/sfr_pkg.sv
// Shared types and constants of the sensor frame receiver.
package sfr_pkg;

    localparam int unsigned MAX_VALUES_DEF = 8;
    localparam int unsigned VALUE_BITS_DEF = 32;
    localparam int unsigned RUN_DEPTH      = 3;

    localparam logic [1:0] KIND_TX    = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] CFG_READY_CODE    = 2'd0;
    localparam logic [1:0] CFG_ACK_CODE      = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ID,
        PH_COUNT,
        PH_CMD,
        PH_LEN,
        PH_DATA
    } t_phase;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [7:0]  value_cmd;
        logic [31:0] value_data;
        logic [2:0]  value_index;
        logic        last_of_run;
    } t_out_beat;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  sender_id;
        logic [7:0]  values_left;
        logic [7:0]  value_count;
        logic [7:0]  current_cmd;
        logic [7:0]  bytes_left;
        logic [15:0] idle_ticks;
    } t_frame_state;

    typedef struct packed {
        logic [7:0]  ready_code;
        logic [7:0]  ack_code;
        logic [15:0] timeout_ticks;
    } t_cfg;

endpackage

// File: rtl/sfr_step.sv
// Next-state and result logic for one received byte or tick.
module sfr_step import sfr_pkg::*; #(
    parameter int unsigned MAX_VALUES = MAX_VALUES_DEF,
    parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
    input  t_cfg                  i_cfg,
    input  t_frame_state          i_state,
    input  logic [VALUE_BITS-1:0] i_acc,
    input  t_in_beat              i_beat,
    output t_frame_state          o_state,
    output logic [VALUE_BITS-1:0] o_acc,
    output t_out_beat             o_res [RUN_DEPTH],
    output logic [1:0]            o_count
);

    function automatic t_out_beat mk_result(input logic [1:0] kind, input logic [7:0] tx,
                                            input logic [7:0] cmd, input logic [31:0] data,
                                            input logic [2:0] idx);
        t_out_beat r;
        r.kind        = kind;
        r.tx_byte     = tx;
        r.value_cmd   = cmd;
        r.value_data  = data;
        r.value_index = idx;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    logic [15:0] ticks;
    logic [15:0] limit;
    logic        finish;
    logic        send_ack;

    always_comb begin
        o_state  = i_state;
        o_acc    = i_acc;
        for (int k = 0; k < RUN_DEPTH; k++) begin
            o_res[k] = '0;
        end
        o_count  = 2'd0;
        finish   = 1'b0;
        send_ack = 1'b0;
        ticks    = 16'(i_state.idle_ticks + 16'd1);
        limit    = (i_cfg.timeout_ticks == 16'd0) ? 16'd1 : i_cfg.timeout_ticks;

        if (i_beat.mode) begin
            if (i_state.phase != PH_IDLE) begin
                o_state.idle_ticks = ticks;
                if (ticks >= limit) begin
                    o_res[o_count]     = mk_result(KIND_ERROR, 8'd0, 8'd0, 32'd0, 3'd0);
                    o_count            = 2'(o_count + 2'd1);
                    o_state.phase      = PH_IDLE;
                    o_state.idle_ticks = 16'd0;
                end
            end
        end else begin
            o_state.idle_ticks = 16'd0;
            case (i_state.phase)
                PH_IDLE: begin
                    if (i_beat.rx_byte == i_cfg.ready_code) begin
                        o_state.phase = PH_ID;
                    end
                end
                PH_ID: begin
                    o_state.sender_id = i_beat.rx_byte;
                    o_state.phase     = PH_COUNT;
                end
                PH_COUNT: begin
                    o_state.values_left = i_beat.rx_byte;
                    o_state.value_count = 8'd0;
                    o_res[o_count] = mk_result(KIND_TX, i_state.sender_id, 8'd0, 32'd0, 3'd0);
                    o_count        = 2'(o_count + 2'd1);
                    if (i_beat.rx_byte == 8'd0) begin
                        send_ack = 1'b1;
                    end else begin
                        o_state.phase = PH_CMD;
                    end
                end
                PH_CMD: begin
                    o_state.current_cmd = i_beat.rx_byte;
                    o_state.phase       = PH_LEN;
                end
                PH_LEN: begin
                    o_state.bytes_left = i_beat.rx_byte;
                    o_acc              = '0;
                    if (i_beat.rx_byte == 8'd0) begin
                        finish = 1'b1;
                    end else begin
                        o_state.phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    o_acc              = VALUE_BITS'({i_acc, i_beat.rx_byte});
                    o_state.bytes_left = 8'(i_state.bytes_left - 8'd1);
                    if (o_state.bytes_left == 8'd0) begin
                        finish = 1'b1;
                    end
                end
                default: begin
                    o_state.phase = PH_IDLE;
                end
            endcase
        end

        // A completed value is reported only while it fits the store limit.
        if (finish) begin
            if (o_state.value_count < 8'(MAX_VALUES)) begin
                o_res[o_count] = mk_result(KIND_VALUE, 8'd0, o_state.current_cmd,
                                           32'(o_acc), o_state.value_count[2:0]);
                o_count        = 2'(o_count + 2'd1);
            end
            o_state.value_count = 8'(o_state.value_count + 8'd1);
            o_state.values_left = 8'(o_state.values_left - 8'd1);
            if (o_state.values_left == 8'd0) begin
                send_ack = 1'b1;
            end else begin
                o_state.phase = PH_CMD;
            end
        end

        if (send_ack) begin
            o_res[o_count] = mk_result(KIND_TX, i_cfg.ack_code, 8'd0, 32'd0, 3'd0);
            o_count        = 2'(o_count + 2'd1);
            o_res[o_count] = mk_result(KIND_TX, o_state.sender_id, 8'd0, 32'd0, 3'd0);
            o_count        = 2'(o_count + 2'd1);
            o_state.phase  = PH_IDLE;
        end

        if (o_count != 2'd0) begin
            o_res[2'(o_count - 2'd1)].last_of_run = 1'b1;
        end
    end

endmodule

// File: rtl/sensor_frame_receiver_unit.sv
// Top level of the sensor frame receiver: state, configuration and result buffer.
//
// Usage: each input beat on i_in_* is either one received radio byte (mode 0) or
// one millisecond tick (mode 1). A beat is taken at a clock edge where i_in_valid
// is high and o_in_stall is low. Results leave on o_out_* one beat at a time and
// are taken where o_out_valid is high and i_out_stall is low; one input beat gives
// zero to three results, the final one marked by last_of_run.
// Results are registered: the results of a beat appear in the cycle after it is taken.
// Throughput is one input beat per cycle while beats give at most one result each and
// the output does not stall; a beat that gives two or three results holds the input
// off until its last result leaves, as the three-entry buffer drains one beat per cycle.
// The configuration channel (ready code, ack code, timeout) is always ready and
// should be written only while no frame traffic is in flight.
// When the receiver stalls, the current result beat holds and the input side is
// stalled once the buffer cannot take a new run; nothing is lost.
// Reset is synchronous and active low: the frame parser returns to idle, the
// result buffer empties and the registers return to ready 0, ack 0, timeout 1000.
module sensor_frame_receiver_unit import sfr_pkg::*; #(
    parameter int unsigned MAX_VALUES = MAX_VALUES_DEF,
    parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_beat  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_beat o_out_data,
    input  logic      i_out_stall,
    input  logic      i_cfg_valid,
    input  logic [1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic      o_cfg_ready
);

    t_cfg                  r_cfg;
    t_frame_state          r_state;
    t_frame_state          n_state;
    logic [VALUE_BITS-1:0] r_acc;
    logic [VALUE_BITS-1:0] n_acc;
    t_out_beat             r_res [RUN_DEPTH];
    t_out_beat             n_res [RUN_DEPTH];
    logic [1:0]            n_count;
    logic [1:0]            r_pos;
    logic [1:0]            r_left;
    logic                  in_take;
    logic                  out_take;

    // Registers are plain flops, so a write can be taken in every cycle.
    assign o_cfg_ready = 1'b1;

    assign o_out_valid = (r_left != 2'd0);
    assign o_out_data  = r_res[r_pos];
    assign out_take    = o_out_valid && !i_out_stall;

    // A new beat may enter when the buffer is empty or hands over its last result now.
    assign o_in_stall = !((r_left == 2'd0) || ((r_left == 2'd1) && !i_out_stall));
    assign in_take    = i_in_valid && !o_in_stall;

    sfr_step #(
        .MAX_VALUES(MAX_VALUES),
        .VALUE_BITS(VALUE_BITS)
    ) u_step (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_acc   (r_acc),
        .i_beat  (i_in_data),
        .o_state (n_state),
        .o_acc   (n_acc),
        .o_res   (n_res),
        .o_count (n_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ready_code    <= 8'd0;
            r_cfg.ack_code      <= 8'd0;
            r_cfg.timeout_ticks <= TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_READY_CODE:    r_cfg.ready_code    <= i_cfg_data[7:0];
                CFG_ACK_CODE:      r_cfg.ack_code      <= i_cfg_data[7:0];
                CFG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, default: '0};
            r_acc   <= '0;
        end else if (in_take) begin
            r_state <= n_state;
            r_acc   <= n_acc;
        end
    end

    // Result buffer: a run is loaded whole and then read out in order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 2'd0;
            r_left <= 2'd0;
        end else if (in_take && (n_count != 2'd0)) begin
            r_pos  <= 2'd0;
            r_left <= n_count;
        end else if (out_take) begin
            r_pos  <= 2'(r_pos + 2'd1);
            r_left <= 2'(r_left - 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && (n_count != 2'd0)) begin
            r_res <= n_res;
        end
    end

    // The read position plus the results still to go never passes the buffer depth.
    a_buf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (3'(r_pos) + 3'(r_left)) <= 3'(RUN_DEPTH))
        else $error("result buffer position out of range");

    // Only the final result of a run carries the last_of_run mark.
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last_of_run == (r_left == 2'd1)))
        else $error("last_of_run does not match the end of the run");

    // A timeout error is shown only once the parser has dropped back to idle.
    a_err_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.kind == KIND_ERROR)) |-> (r_state.phase == PH_IDLE))
        else $error("frame error shown while a frame is still open");

    // Loading a run while old results wait would drop them.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && (r_left > 2'd1)) |-> 1'b0)
        else $error("input taken while the result buffer still holds a run");

endmodule
